[sv/rtcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Range-to-CIDR splitter package
// Shared widths, the queue entry type, the queue status type and the bit-scan
// helpers used by the front and back ends.
// ----------------------------------------------------------------------------
package rtcs_pkg;

    localparam int ADDR_W = 32;
    localparam int SIZE_W = ADDR_W + 1;
    localparam int PLEN_W = 6;

    // One address beyond the top of the address space.
    localparam logic [SIZE_W-1:0] SPACE_SIZE = {1'b1, {ADDR_W{1'b0}}};

    // A clipped range waiting to be split: first address and remaining count.
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] remain;
    } t_range;

    // Fill status of the queue between the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Trailing zero count; an all-zero address counts as fully aligned.
    function automatic logic [PLEN_W-1:0] f_trail_zeros(input logic [ADDR_W-1:0] a);
        logic [PLEN_W-1:0] n;
        n = PLEN_W'(ADDR_W);
        for (int i = ADDR_W - 1; i >= 0; i--) begin
            if (a[i]) begin
                n = PLEN_W'(i);
            end
        end
        return n;
    endfunction

    // Index of the highest set bit; the value is never zero where it is used.
    function automatic logic [PLEN_W-1:0] f_floor_log2(input logic [SIZE_W-1:0] v);
        logic [PLEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (v[i]) begin
                n = PLEN_W'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[sv/rtcs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Range-to-CIDR splitter front end
// Accepts range items, drops empty ranges, clips a range at the top of the
// address space and holds the result in one register for the queue.
// ----------------------------------------------------------------------------
module rtcs_front import rtcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ADDR_W-1:0] i_range_start,
    input  wire logic [ADDR_W-1:0] i_range_count,
    output logic                   o_stall,
    output logic                   o_push_valid,
    output t_range                 o_push_data,
    input  wire logic              i_q_full
);

    logic              r_valid;
    logic              n_valid;
    t_range            r_range;
    logic [SIZE_W-1:0] space_left;
    logic [SIZE_W-1:0] count_ext;
    logic              take;
    logic              push_done;

    // Clip the count so that the range ends at the top of the space at most.
    always_comb begin
        space_left = SPACE_SIZE - {1'b0, i_range_start};
        count_ext  = {1'b0, i_range_count};
    end

    assign o_stall   = r_valid && i_q_full;
    assign push_done = r_valid && !i_q_full;
    // An empty range is accepted and then dropped.
    assign take      = i_valid && !o_stall && (i_range_count != '0);

    always_comb begin
        n_valid = r_valid;
        if (push_done) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_range.start  <= i_range_start;
            r_range.remain <= (count_ext < space_left) ? count_ext : space_left;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_data  = r_range;

endmodule
`default_nettype wire

[sv/rtcs_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Range-to-CIDR splitter queue
// Two-entry queue of clipped ranges between the front and back ends.
// ----------------------------------------------------------------------------
module rtcs_queue import rtcs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_range    i_push_data,
    input  wire logic i_pop,
    output t_range    o_pop_data,
    output t_q_status o_status
);

    t_range     r_slot0;
    t_range     r_slot1;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push && !r_wr_ptr) begin
            r_slot0 <= i_push_data;
        end
        if (do_push && r_wr_ptr) begin
            r_slot1 <= i_push_data;
        end
    end

    assign o_pop_data = r_rd_ptr ? r_slot1 : r_slot0;

endmodule
`default_nettype wire

[sv/rtcs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Range-to-CIDR splitter back end
// Takes one clipped range from the queue and emits one aligned block per
// cycle, unless stalled, into the output register until the range is covered.
// ----------------------------------------------------------------------------
module rtcs_back import rtcs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_q_status               i_q_status,
    input  t_range                  i_pop_data,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ADDR_W-1:0]       o_block_address,
    output logic [PLEN_W-1:0]       o_prefix_length,
    output logic [SIZE_W-1:0]       o_block_size,
    output logic                    o_last_block
);

    logic              r_busy;
    logic [ADDR_W-1:0] r_cursor;
    logic [SIZE_W-1:0] r_remain;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [PLEN_W-1:0] r_plen;
    logic [SIZE_W-1:0] r_size;
    logic              r_last;
    logic [PLEN_W-1:0] tz;
    logic [PLEN_W-1:0] lg;
    logic [PLEN_W-1:0] k;
    logic [SIZE_W-1:0] size;
    logic              last;
    logic              step;

    // Block size is the smaller of the alignment and the remaining count.
    always_comb begin
        tz   = f_trail_zeros(r_cursor);
        lg   = f_floor_log2(r_remain);
        k    = (tz < lg) ? tz : lg;
        size = SIZE_W'(1) << k;
        last = (r_remain == size);
    end

    assign step  = r_busy && (!r_out_valid || !i_stall);
    assign o_pop = !r_busy && !i_q_status.empty;

    // Control: busy while a range is being split, output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (step && last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Cursor and remaining count.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cursor <= i_pop_data.start;
            r_remain <= i_pop_data.remain;
        end else if (step) begin
            r_cursor <= r_cursor + size[ADDR_W-1:0];
            r_remain <= r_remain - size;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_addr <= r_cursor;
            r_plen <= PLEN_W'(ADDR_W) - k;
            r_size <= size;
            r_last <= last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_block_address = r_addr;
    assign o_prefix_length = r_plen;
    assign o_block_size    = r_size;
    assign o_last_block    = r_last;

endmodule
`default_nettype wire

[sv/range_to_cidr_splitter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 range to CIDR splitter
// The first block of a range passes through the front register, the queue,
// the back end's cursor registers and the output register. The back end emits
// one block per cycle while the receiver does not stall, and loads each range
// before it splits it, taking no new range until the current one is split.
// Empty ranges are accepted and give no block. The synchronous active-low
// reset empties the front register, the queue and the output register.
// ----------------------------------------------------------------------------
module range_to_cidr_splitter_top import rtcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ADDR_W-1:0] i_range_start,
    input  wire logic [ADDR_W-1:0] i_range_count,
    output logic                   o_stall,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [ADDR_W-1:0]      o_block_address,
    output logic [PLEN_W-1:0]      o_prefix_length,
    output logic [SIZE_W-1:0]      o_block_size,
    output logic                   o_last_block
);

    logic      push_valid;
    t_range    push_data;
    t_range    pop_data;
    logic      pop;
    t_q_status q_status;

    rtcs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_range_start (i_range_start),
        .i_range_count (i_range_count),
        .o_stall       (o_stall),
        .o_push_valid  (push_valid),
        .o_push_data   (push_data),
        .i_q_full      (q_status.full)
    );

    rtcs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    rtcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_status      (q_status),
        .i_pop_data      (pop_data),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_block_address (o_block_address),
        .o_prefix_length (o_prefix_length),
        .o_block_size    (o_block_size),
        .o_last_block    (o_last_block)
    );

    // Every emitted block is aligned to its own size.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_block_size[ADDR_W-1:0] - ADDR_W'(1)) & o_block_address) == '0)
        else $error("emitted block is not aligned to its size");

    // Size and prefix length describe the same block.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_block_size == (SIZE_W'(1) << (PLEN_W'(ADDR_W) - o_prefix_length)))
        else $error("block size does not match prefix length");

    // The queue never reports full and empty together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue status is inconsistent");

endmodule
`default_nettype wire

[bench/range_to_cidr_splitter_top_tb.sv]
// ----------------------------------------------------------------------------
// Range-to-CIDR splitter testbench
// Feeds IPv4 ranges (start address and address count) into the splitter and
// checks every CIDR block that comes out against a block list worked out in
// the bench. Directed ranges cover the corners of the address space, then
// about ninety random ranges follow. Both handshakes idle and stall at
// random, with one long receiver hold-off and one full drain on the way.
// ----------------------------------------------------------------------------
module range_to_cidr_splitter_top_tb;
    import rtcs_pkg::*;

    localparam int RANDOM_RANGES = 92;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 1_500_000;

    // One CIDR block as it leaves the splitter.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic [SIZE_W-1:0] size;
        logic              last;
    } t_cidr_block;

    // Keeps the CIDR blocks still owed by the splitter, oldest first.
    class cidr_scoreboard;
        t_cidr_block owed_blocks[$];
        int          errors;
        int          ranges_noted;
        int          empty_ranges;
        int          blocks_checked;

        // Splits an accepted range into its blocks and queues them.
        function void note_range(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] count);
            logic [SIZE_W:0] cursor;
            logic [SIZE_W:0] stop;
            logic [SIZE_W:0] left;
            int              tz;
            int              lg;
            t_cidr_block     blk;
            cursor = {2'b00, start};
            stop = cursor + {2'b00, count};
            // Ranges running past the top end at the top of the space.
            if (stop > {1'b0, SPACE_SIZE}) begin
                stop = {1'b0, SPACE_SIZE};
            end
            ranges_noted++;
            if (cursor >= stop) begin
                empty_ranges++;
            end
            while (cursor < stop) begin
                // Address zero counts as aligned to the whole space.
                tz = 0;
                while (tz < ADDR_W && !cursor[tz]) begin
                    tz++;
                end
                left = stop - cursor;
                lg = SIZE_W;
                while (!left[lg]) begin
                    lg--;
                end
                if (lg < tz) begin
                    tz = lg;
                end
                blk.addr = cursor[ADDR_W-1:0];
                blk.plen = PLEN_W'(ADDR_W - tz);
                blk.size = SIZE_W'(1) << tz;
                cursor = cursor + (SIZE_W'(1) << tz);
                blk.last = (cursor >= stop);
                owed_blocks.push_back(blk);
            end
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares one block from the splitter with the oldest one owed.
        function void check_block(t_cidr_block got);
            t_cidr_block want;
            if (owed_blocks.size() == 0) begin
                $display("%0t: unexpected block %h/%0d size %h last %b", $time,
                         got.addr, got.plen, got.size, got.last);
                errors++;
                return;
            end
            want = owed_blocks.pop_front();
            blocks_checked++;
            report_field("block_address", 64'(want.addr), 64'(got.addr));
            report_field("prefix_length", 64'(want.plen), 64'(got.plen));
            report_field("block_size", 64'(want.size), 64'(got.size));
            report_field("last_block", 64'(want.last), 64'(got.last));
        endfunction

        function int owed();
            return owed_blocks.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [ADDR_W-1:0] i_range_start = '0;
    logic [ADDR_W-1:0] i_range_count = '0;
    logic              o_stall;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [ADDR_W-1:0] o_block_address;
    logic [PLEN_W-1:0] o_prefix_length;
    logic [SIZE_W-1:0] o_block_size;
    logic              o_last_block;

    cidr_scoreboard sb;
    bit             hold_request = 1'b0;
    bit             rx_quiet = 1'b0;
    bit             tx_quiet = 1'b0;
    int             longest_hold = 0;
    int             cycle_count = 0;

    range_to_cidr_splitter_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_range_start  (i_range_start),
        .i_range_count  (i_range_count),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_block_address(o_block_address),
        .o_prefix_length(o_prefix_length),
        .o_block_size   (o_block_size),
        .o_last_block   (o_last_block)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Offers one range and waits until the splitter takes it.
    task automatic send_range(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] count);
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_range_start <= start;
        i_range_count <= count;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        sb.note_range(start, count);
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Withdraws the offer, then waits for every owed block.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.owed() > 0) begin
            @(posedge i_clk);
        end
    endtask

    // Builds a random range, mostly shapes that give long block runs.
    task automatic send_random_range();
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] count;
        int                kind;
        kind = $urandom_range(0, 99);
        start = $urandom;
        if (kind < 25) begin
            count = $urandom;
        end else if (kind < 50) begin
            count = $urandom_range(1, 4096);
        end else if (kind < 70) begin
            start = start & ({ADDR_W{1'b1}} << $urandom_range(0, 31));
            count = 32'h1 << $urandom_range(0, 31);
        end else if (kind < 85) begin
            start = 32'hFFFF_FFFF - $urandom_range(0, 65535);
            count = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1, 200000);
        end else if (kind < 95) begin
            count = $urandom >> $urandom_range(0, 31);
        end else begin
            count = '0;
        end
        send_range(start, count);
    endtask

    // Receiver: random stall pattern, a long hold-off on request.
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
                longest_hold = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else if (run_left > 0 || rx_quiet) begin
                i_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end
            end else begin
                i_stall <= 1'b0;
                stall_left = pick_gap();
                run_left = $urandom_range(1, 30);
            end
        end
    end

    // Every block the splitter hands over is checked at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_block('{addr: o_block_address, plen: o_prefix_length,
                             size: o_block_size, last: o_last_block});
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d blocks still owed", $time, sb.owed());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus: reset, directed corners, then random ranges.
    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Corner ranges: empty, address zero, the top of the space and clipping.
        send_range(32'h0000_0000, 32'h0000_0000);
        send_range(32'h1234_5678, 32'h0000_0000);
        send_range(32'h0000_0000, 32'h0000_0001);
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_range(32'h0000_0000, 32'h8000_0000);
        send_range(32'hFFFF_FFFF, 32'h0000_0001);
        send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_range(32'h8000_0000, 32'h8000_0000);
        send_range(32'h8000_0000, 32'hFFFF_FFFF);
        send_range(32'h0000_0001, 32'hFFFF_FFFF);
        send_range(32'h0000_0001, 32'hFFFF_FFFE);
        send_range(32'hFFFF_FF00, 32'h0000_0200);
        send_range(32'hFFFF_FFFE, 32'h0000_0003);
        send_range(32'h7FFF_FFFF, 32'h0000_0002);
        send_range(32'hC0A8_0000, 32'h0000_0100);
        send_range(32'hC0A8_0001, 32'h0000_00FE);
        send_range(32'h0A00_0000, 32'h0100_0000);
        send_range(32'hAAAA_AAAA, 32'h5555_5555);
        send_range(32'h5555_5555, 32'hAAAA_AAAA);
        wait_for_drain();

        for (int n = 0; n < RANDOM_RANGES; n++) begin
            // Long receiver hold-off while the sender keeps offering ranges.
            if (n == 30) begin
                hold_request = 1'b1;
                tx_quiet = 1'b1;
            end
            if (n == 50) begin
                tx_quiet = 1'b0;
            end
            // Sender pauses until every owed block has come out.
            if (n == 60) begin
                wait_for_drain();
            end
            // A stretch with no idling on either side.
            if (n == 75) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            if (n == 88) begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            send_random_range();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d ranges (%0d empty) and %0d CIDR blocks,",
                 sb.ranges_noted, sb.empty_ranges, sb.blocks_checked);
        $display("with a receiver hold-off of %0d cycles and a full drain.", longest_hold);
        if (sb.errors == 0 && sb.owed() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
